[sv/sesl_pkg.sv]
// ----------------------------------------------------------------------------
// sesl_pkg
// Shared types and constants of the SES SAS-address slot locator.
// ----------------------------------------------------------------------------
package sesl_pkg;

    localparam int MAX_PAGE_BYTES = 4096;
    localparam int MAX_TYPES      = 64;
    localparam int TYPE_AW        = $clog2(MAX_TYPES);
    localparam int TCNT_W         = $clog2(MAX_TYPES + 1);

    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_CAP = 17'h1FFFF;

    localparam logic [7:0] CFG_CODE   = 8'h01;
    localparam logic [7:0] AES_CODE   = 8'h0a;
    localparam logic [3:0] PROTO_SAS  = 4'd6;
    localparam int         HDR_BYTES  = 4;
    localparam int         PHY_BYTES  = 28;

    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] REG_TARGET = 4'd0;

    typedef struct packed {
        logic step;
        logic walk_rd;
        logic walk_cmp;
    } sesl_cmd_t;

    typedef struct packed {
        logic need_walk;
        logic walk_exhausted;
        logic walk_hit;
        logic load;
    } sesl_stat_t;

endpackage

[sv/sesl_ram.sv]
// ----------------------------------------------------------------------------
// sesl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sesl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/sesl_ctrl.sv]
// ----------------------------------------------------------------------------
// sesl_ctrl
// Controller: byte acceptance, type-table walk sequencing and result valid.
// ----------------------------------------------------------------------------
module sesl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sesl_pkg::sesl_cmd_t cmd,
    input  sesl_pkg::sesl_stat_t stat
);
    import sesl_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_RD,
        ST_CMP
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready     = (state_reg == ST_RUN) && !out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign cmd.step     = in_valid && in_ready;
    assign cmd.walk_rd  = (state_reg == ST_RD);
    assign cmd.walk_cmp = (state_reg == ST_CMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_RUN:
                begin
                    if (cmd.step && stat.need_walk)
                    begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= stat.walk_exhausted ? ST_RUN : ST_CMP;
                end
                ST_CMP:
                begin
                    state_reg <= stat.walk_hit ? ST_RUN : ST_RD;
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
            if (stat.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/sesl_dp.sv]
// ----------------------------------------------------------------------------
// sesl_dp
// Datapath: page parser, type-count table, index walk and result register.
// ----------------------------------------------------------------------------
module sesl_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sesl_pkg::sesl_cmd_t  cmd,
    output sesl_pkg::sesl_stat_t stat,
    input  logic                 mode,
    input  logic [7:0]           page_byte,
    input  logic                 last_byte,
    input  logic                 cfg_we,
    input  logic [63:0]          cfg_wdata,
    output logic [63:0]          target,
    output logic                 found,
    output logic [8:0]           element_index,
    output logic                 page_fault
);
    import sesl_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_ENC,
        PH_TYPE,
        PH_DESC,
        PH_SAS,
        PH_PHY,
        PH_SKIP,
        PH_IDLE
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  page_end_reg, page_end_next;
    logic [POS_W-1:0]  section_end_reg, section_end_next;
    logic [4:0]        unit_reg, unit_next;
    logic [8:0]        encl_reg, encl_next;
    logic [POS_W-1:0]  headers_reg, headers_next;
    logic [TCNT_W-1:0] type_total_reg, type_total_next;
    logic [7:0]        raw_index_reg, raw_index_next;
    logic [7:0]        flags_reg, flags_next;
    logic [7:0]        phys_reg, phys_next;
    logic [63:0]       addr_reg, addr_next;
    logic [63:0]       target_reg;
    logic              in_page_reg, in_page_next;
    logic              cur_mode_reg, cur_mode_next;
    logic              match_reg, match_next;
    logic              code_ok_reg, code_ok_next;
    logic              cfg_ok_reg, cfg_ok_next;
    logic              cfg_fault_reg, cfg_fault_next;
    logic              st_fault_reg, st_fault_next;
    logic              eiioe_reg, eiioe_next;
    logic              slot_ok_reg, slot_ok_next;
    logic              hit_ok_reg, hit_ok_next;
    logic [8:0]        hit_index_reg, hit_index_next;
    logic              pend_last_reg, pend_last_next;
    logic [7:0]        walk_idx_reg, walk_idx_next;
    logic [TCNT_W-1:0] walk_i_reg, walk_i_next;
    logic              found_reg, found_next;
    logic [8:0]        index_reg, index_next;
    logic              fault_reg, fault_next;

    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic              need_walk;
    logic              load;

    logic [POS_W-1:0]  p;
    logic [POS_W-1:0]  p1;
    logic [POS_W-1:0]  pb;
    logic              do_tail;
    logic              qual;
    logic              trunc;
    logic              fault;

    assign target = target_reg;
    assign found = found_reg;
    assign element_index = index_reg;
    assign page_fault = fault_reg;

    assign stat.need_walk      = need_walk;
    assign stat.walk_exhausted = (walk_i_reg >= type_total_reg);
    assign stat.walk_hit       = (walk_idx_reg < ram_rdata);
    assign stat.load           = load;

    sesl_ram #(
        .WIDTH(8),
        .DEPTH(MAX_TYPES)
    ) u_type_counts (
        .clk  (clk),
        .we   (ram_we),
        .waddr(type_total_reg[TYPE_AW-1:0]),
        .wdata(raw_index_reg),
        .raddr(walk_i_reg[TYPE_AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        page_end_next    = page_end_reg;
        section_end_next = section_end_reg;
        unit_next        = unit_reg;
        encl_next        = encl_reg;
        headers_next     = headers_reg;
        type_total_next  = type_total_reg;
        raw_index_next   = raw_index_reg;
        flags_next       = flags_reg;
        phys_next        = phys_reg;
        addr_next        = addr_reg;
        in_page_next     = in_page_reg;
        cur_mode_next    = cur_mode_reg;
        match_next       = match_reg;
        code_ok_next     = code_ok_reg;
        cfg_ok_next      = cfg_ok_reg;
        cfg_fault_next   = cfg_fault_reg;
        st_fault_next    = st_fault_reg;
        eiioe_next       = eiioe_reg;
        slot_ok_next     = slot_ok_reg;
        hit_ok_next      = hit_ok_reg;
        hit_index_next   = hit_index_reg;
        pend_last_next   = pend_last_reg;
        walk_idx_next    = walk_idx_reg;
        walk_i_next      = walk_i_reg;
        ram_we           = 1'b0;
        need_walk        = 1'b0;
        load             = 1'b0;
        p                = pos_reg;
        p1               = pos_reg;
        pb               = pos_reg;
        do_tail          = 1'b0;
        qual             = 1'b0;
        trunc            = 1'b0;

        if (cmd.step)
        begin
            // A change of mode drops the unfinished page.
            if (in_page_reg && (mode != cur_mode_reg))
            begin
                if (!cur_mode_reg)
                begin
                    cfg_fault_next = 1'b1;
                    cfg_ok_next    = 1'b0;
                end
                in_page_next = 1'b0;
            end
            if (!in_page_next)
            begin
                in_page_next     = 1'b1;
                cur_mode_next    = mode;
                pos_next         = '0;
                page_end_next    = '0;
                section_end_next = '0;
                phase_next       = PH_HDR;
                unit_next        = '0;
                if (!mode)
                begin
                    cfg_ok_next     = 1'b0;
                    cfg_fault_next  = 1'b0;
                    code_ok_next    = 1'b0;
                    type_total_next = '0;
                    headers_next    = '0;
                    encl_next       = '0;
                end
                else
                begin
                    st_fault_next  = 1'b0;
                    match_next     = 1'b0;
                    hit_ok_next    = 1'b0;
                    hit_index_next = '0;
                    flags_next     = '0;
                    raw_index_next = '0;
                    phys_next      = '0;
                    addr_next      = '0;
                    eiioe_next     = 1'b0;
                    slot_ok_next   = 1'b0;
                end
            end

            p  = pos_next;
            p1 = p + 1'b1;
            pb = p1 + {{(POS_W-8){1'b0}}, page_byte};

            if (!mode)
            begin
                if (p < POS_W'(HDR_BYTES))
                begin
                    unique case (p[1:0])
                        2'd0:
                        begin
                            code_ok_next = (page_byte == CFG_CODE);
                            if (!code_ok_next)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        2'd1:
                        begin
                            encl_next = {1'b0, page_byte} + 9'd1;
                        end
                        2'd2:
                        begin
                            page_end_next = {1'b0, page_byte, 8'h00};
                        end
                        default:
                        begin
                            page_end_next = (page_end_next | {9'd0, page_byte})
                                + POS_W'(HDR_BYTES);
                            if (page_end_next > POS_W'(MAX_PAGE_BYTES))
                            begin
                                cfg_fault_next = 1'b1;
                                phase_next     = PH_IDLE;
                            end
                        end
                    endcase
                end
                else if (p < page_end_next)
                begin
                    unique case (phase_next)
                        PH_HDR:
                        begin
                            if (p == POS_W'(7))
                            begin
                                phase_next = PH_ENC;
                                unit_next  = '0;
                            end
                        end
                        PH_ENC:
                        begin
                            if (unit_next == 5'd2)
                            begin
                                headers_next = headers_next + {9'd0, page_byte};
                            end
                            if (unit_next == 5'd3)
                            begin
                                section_end_next = pb;
                            end
                            if (unit_next != 5'd31)
                            begin
                                unit_next = unit_next + 5'd1;
                            end
                            if ((unit_next >= 5'd4) && (p1 == section_end_next))
                            begin
                                encl_next = encl_next - 9'd1;
                                unit_next = '0;
                                if (encl_next == '0)
                                begin
                                    phase_next = (headers_next == '0) ? PH_IDLE : PH_TYPE;
                                end
                            end
                        end
                        PH_TYPE:
                        begin
                            if (unit_next == 5'd1)
                            begin
                                raw_index_next = page_byte;
                            end
                            if (unit_next == 5'd3)
                            begin
                                if (type_total_next < TCNT_W'(MAX_TYPES))
                                begin
                                    ram_we          = 1'b1;
                                    type_total_next = type_total_next + 1'b1;
                                end
                                headers_next = headers_next - 1'b1;
                                unit_next    = '0;
                                if (headers_next == '0)
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                            else
                            begin
                                unit_next = unit_next + 5'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else
            begin
                if (p < POS_W'(HDR_BYTES))
                begin
                    unique case (p[1:0])
                        2'd0:
                        begin
                            if (page_byte != AES_CODE)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        2'd1:
                        begin
                        end
                        2'd2:
                        begin
                            page_end_next = {1'b0, page_byte, 8'h00};
                        end
                        default:
                        begin
                            page_end_next = (page_end_next | {9'd0, page_byte})
                                + POS_W'(HDR_BYTES);
                            if (page_end_next > POS_W'(MAX_PAGE_BYTES))
                            begin
                                st_fault_next = 1'b1;
                                phase_next    = PH_IDLE;
                            end
                        end
                    endcase
                end
                else if (p < page_end_next)
                begin
                    unique case (phase_next)
                        PH_HDR:
                        begin
                            if (p == POS_W'(7))
                            begin
                                unit_next = '0;
                                if (POS_W'(8) >= page_end_next)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else if (POS_W'(12) > page_end_next)
                                begin
                                    st_fault_next = 1'b1;
                                    phase_next    = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_DESC;
                                end
                            end
                        end
                        PH_DESC:
                        begin
                            if (unit_next == 5'd0)
                            begin
                                flags_next = page_byte;
                                unit_next  = 5'd1;
                            end
                            else if (unit_next == 5'd1)
                            begin
                                if (page_byte < 8'd2)
                                begin
                                    st_fault_next = 1'b1;
                                    phase_next    = PH_IDLE;
                                end
                                else
                                begin
                                    section_end_next = pb;
                                    unit_next        = 5'd2;
                                end
                            end
                            else if (unit_next == 5'd2)
                            begin
                                eiioe_next = page_byte[0];
                                unit_next  = 5'd3;
                            end
                            else
                            begin
                                qual = (flags_next[3:0] == PROTO_SAS) && flags_next[4]
                                    && !flags_next[7];
                                raw_index_next = page_byte;
                                unit_next      = '0;
                                if (!qual)
                                begin
                                    phase_next = PH_SKIP;
                                    do_tail    = 1'b1;
                                end
                                else if (section_end_next > page_end_next)
                                begin
                                    st_fault_next = 1'b1;
                                    phase_next    = PH_IDLE;
                                end
                                else if (section_end_next < p1 + POS_W'(HDR_BYTES))
                                begin
                                    phase_next = PH_SKIP;
                                    do_tail    = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_SAS;
                                end
                            end
                        end
                        PH_SAS:
                        begin
                            if (unit_next == 5'd0)
                            begin
                                phys_next = page_byte;
                            end
                            else if (unit_next == 5'd1)
                            begin
                                slot_ok_next = (page_byte[7:6] == 2'd0);
                            end
                            if (unit_next == 5'd3)
                            begin
                                if (!slot_ok_next || (phys_next == '0))
                                begin
                                    phase_next = PH_SKIP;
                                end
                                else
                                begin
                                    unit_next  = '0;
                                    addr_next  = '0;
                                    phase_next = (p1 + POS_W'(PHY_BYTES) > section_end_next)
                                        ? PH_SKIP : PH_PHY;
                                end
                            end
                            else
                            begin
                                unit_next = unit_next + 5'd1;
                            end
                            do_tail = 1'b1;
                        end
                        PH_PHY:
                        begin
                            if ((unit_next >= 5'd12) && (unit_next < 5'd20))
                            begin
                                addr_next = {addr_next[55:0], page_byte};
                            end
                            if (unit_next == 5'(PHY_BYTES - 1))
                            begin
                                if (addr_next == target_reg)
                                begin
                                    // First match: the search ends here.
                                    match_next = 1'b1;
                                    phase_next = PH_IDLE;
                                    if (eiioe_next)
                                    begin
                                        hit_ok_next    = 1'b1;
                                        hit_index_next = {1'b0, raw_index_next};
                                    end
                                    else if (cfg_ok_next)
                                    begin
                                        need_walk      = 1'b1;
                                        pend_last_next = last_byte;
                                        walk_idx_next  = raw_index_next;
                                        walk_i_next    = '0;
                                    end
                                end
                                else
                                begin
                                    phys_next = phys_next - 8'd1;
                                    do_tail   = 1'b1;
                                    if (phys_next == '0)
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                    else
                                    begin
                                        unit_next  = '0;
                                        addr_next  = '0;
                                        phase_next =
                                            (p1 + POS_W'(PHY_BYTES) > section_end_next)
                                            ? PH_SKIP : PH_PHY;
                                    end
                                end
                            end
                            else
                            begin
                                unit_next = unit_next + 5'd1;
                                do_tail   = 1'b1;
                            end
                        end
                        PH_SKIP:
                        begin
                            do_tail = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    // End of a descriptor: next one, else page end or fault.
                    if (do_tail && (p1 == section_end_next))
                    begin
                        unit_next = '0;
                        if (section_end_next >= page_end_next)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (section_end_next + POS_W'(HDR_BYTES) > page_end_next)
                        begin
                            st_fault_next = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_DESC;
                        end
                    end
                end
            end

            if (pos_next != POS_CAP)
            begin
                pos_next = pos_next + 1'b1;
            end

            if (last_byte)
            begin
                in_page_next = 1'b0;
                trunc = (p < POS_W'(3)) || (p1 < page_end_next);
                if (!mode)
                begin
                    cfg_fault_next = cfg_fault_next | trunc;
                    cfg_ok_next    = !cfg_fault_next && code_ok_next;
                end
                else
                begin
                    st_fault_next = st_fault_next | trunc;
                    load          = !need_walk;
                end
            end
        end

        if (cmd.walk_rd && stat.walk_exhausted)
        begin
            load = pend_last_reg;
        end
        if (cmd.walk_cmp)
        begin
            if (stat.walk_hit)
            begin
                hit_ok_next    = 1'b1;
                hit_index_next = {1'b0, walk_idx_reg} + {2'd0, walk_i_reg} + 9'd1;
                load           = pend_last_reg;
            end
            else
            begin
                walk_idx_next = walk_idx_reg - ram_rdata;
                walk_i_next   = walk_i_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        fault      = st_fault_next || cfg_fault_next;
        found_next = !fault && match_next && hit_ok_next;
        index_next = found_next ? hit_index_next : 9'd0;
        fault_next = fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR;
            pos_reg         <= '0;
            page_end_reg    <= '0;
            section_end_reg <= '0;
            unit_reg        <= '0;
            encl_reg        <= '0;
            headers_reg     <= '0;
            type_total_reg  <= '0;
            raw_index_reg   <= '0;
            flags_reg       <= '0;
            phys_reg        <= '0;
            addr_reg        <= '0;
            target_reg      <= '0;
            in_page_reg     <= 1'b0;
            cur_mode_reg    <= 1'b0;
            match_reg       <= 1'b0;
            code_ok_reg     <= 1'b0;
            cfg_ok_reg      <= 1'b0;
            cfg_fault_reg   <= 1'b0;
            st_fault_reg    <= 1'b0;
            eiioe_reg       <= 1'b0;
            slot_ok_reg     <= 1'b0;
            hit_ok_reg      <= 1'b0;
            hit_index_reg   <= '0;
            pend_last_reg   <= 1'b0;
            walk_idx_reg    <= '0;
            walk_i_reg      <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            page_end_reg    <= page_end_next;
            section_end_reg <= section_end_next;
            unit_reg        <= unit_next;
            encl_reg        <= encl_next;
            headers_reg     <= headers_next;
            type_total_reg  <= type_total_next;
            raw_index_reg   <= raw_index_next;
            flags_reg       <= flags_next;
            phys_reg        <= phys_next;
            addr_reg        <= addr_next;
            in_page_reg     <= in_page_next;
            cur_mode_reg    <= cur_mode_next;
            match_reg       <= match_next;
            code_ok_reg     <= code_ok_next;
            cfg_ok_reg      <= cfg_ok_next;
            cfg_fault_reg   <= cfg_fault_next;
            st_fault_reg    <= st_fault_next;
            eiioe_reg       <= eiioe_next;
            slot_ok_reg     <= slot_ok_next;
            hit_ok_reg      <= hit_ok_next;
            hit_index_reg   <= hit_index_next;
            pend_last_reg   <= pend_last_next;
            walk_idx_reg    <= walk_idx_next;
            walk_i_reg      <= walk_i_next;
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg <= found_next;
            index_reg <= index_next;
            fault_reg <= fault_next;
        end
    end

endmodule

[sv/ses_sas_address_slot_locator.sv]
// ----------------------------------------------------------------------------
// ses_sas_address_slot_locator
// Finds the status element index of a device slot by its SAS address.
// ----------------------------------------------------------------------------
// The block takes one page byte per cycle: first an SES configuration page
// (tuser low), then additional element status pages (tuser high), each ended
// by tlast. One result beat follows the last byte of every status page. When
// the matching descriptor has EIIOE clear, the index is corrected by walking
// the stored type counts through the type-count RAM, with a read state and
// a compare state per type header, and input is held off meanwhile. A finished
// result is held in an output register; no byte is taken while it waits.
module ses_sas_address_slot_locator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] page_byte
    input  logic        s_axis_tuser,   // [0] mode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] found, [9:1] element_index,
                                        // [10] page_fault, [15:11] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [sesl_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import sesl_pkg::*;

    sesl_cmd_t   cmd;
    sesl_stat_t  stat;
    logic [63:0] target;
    logic        cfg_we;
    logic        found;
    logic [8:0]  element_index;
    logic        page_fault;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_TARGET[ADDR_W-1]);
    assign prdata = (paddr[ADDR_W-1] == REG_TARGET[ADDR_W-1]) ? target : 64'd0;
    assign m_axis_tdata = {5'd0, page_fault, element_index, found};

    sesl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sesl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (s_axis_tuser),
        .page_byte    (s_axis_tdata),
        .last_byte    (s_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_wdata    (pwdata),
        .target       (target),
        .found        (found),
        .element_index(element_index),
        .page_fault   (page_fault)
    );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SES SAS-address slot locator.
// ----------------------------------------------------------------------------
// Configuration and additional element status pages are streamed in, mostly
// well formed with random content and with a share of damaged pages. A
// built-in parser computes the slot result of every status page. Each result
// beat is compared field by field. The target address is rewritten between
// phases while the block is idle.
module tb_top;
    import sesl_pkg::*;

    typedef enum int {PH_HDR, PH_ENC, PH_TYPE, PH_DESC, PH_SAS, PH_PHY, PH_SKIP, PH_IDLE}
        walk_phase_e;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       eop;
    } page_beat_t;

    typedef struct packed {
        logic       found;
        logic [8:0] element_index;
        logic       page_fault;
    } slot_result_t;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] page_byte
    logic        s_axis_tuser = 1'b0; // [0] mode
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [0] found, [9:1] element_index, [10] page_fault
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    ses_sas_address_slot_locator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 clk = ~clk;

    page_beat_t   beat_q[$];
    slot_result_t slot_results_q[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  hits_seen = 0;
    int  faults_seen = 0;
    int  pages_sent = 0;
    bit  calm = 1'b0;
    int  quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Parser state mirrored from the block's behavior.
    // ------------------------------------------------------------------
    logic [63:0]  target_addr = '0;
    int unsigned  pos, pg_end, sec_end, enc_left, type_cnt, hdrs_left, upos, hit_idx;
    walk_phase_e  phase;
    logic [7:0]   poss_elems[MAX_TYPES];
    logic [7:0]   desc_flags, raw_idx, phys_left;
    logic [63:0]  addr_shift;
    bit in_page, cur_mode, code_ok, cfg_ok, cfg_fault, st_fault;
    bit eiioe, slot_ok, hit_ok, match_seen;

    function automatic void begin_page(bit mode);
        in_page = 1'b1;
        cur_mode = mode;
        pos = 0;
        pg_end = 0;
        sec_end = 0;
        phase = PH_HDR;
        upos = 0;
        if (!mode)
        begin
            cfg_ok = 1'b0;
            cfg_fault = 1'b0;
            code_ok = 1'b0;
            type_cnt = 0;
            hdrs_left = 0;
            enc_left = 0;
        end
        else
        begin
            st_fault = 1'b0;
            match_seen = 1'b0;
            hit_ok = 1'b0;
            hit_idx = 0;
            desc_flags = '0;
            raw_idx = '0;
            phys_left = '0;
            addr_shift = '0;
            eiioe = 1'b0;
            slot_ok = 1'b0;
        end
    endfunction

    function automatic void cfg_byte(int unsigned p, logic [7:0] b);
        if (p < HDR_BYTES)
        begin
            if (p == 0)
            begin
                code_ok = (b == CFG_CODE);
                if (!code_ok) phase = PH_IDLE;
            end
            else if (p == 1) enc_left = b + 1;
            else if (p == 2) pg_end = b << 8;
            else
            begin
                pg_end = (pg_end | b) + 4;
                if (pg_end > MAX_PAGE_BYTES)
                begin
                    cfg_fault = 1'b1;
                    phase = PH_IDLE;
                end
            end
            return;
        end
        if (p >= pg_end) return;
        case (phase)
            PH_HDR:
                if (p == 7)
                begin
                    phase = PH_ENC;
                    upos = 0;
                end
            PH_ENC:
            begin
                if (upos == 2) hdrs_left += b;
                if (upos == 3) sec_end = p + 1 + b;
                upos++;
                if (upos >= 4 && p + 1 == sec_end)
                begin
                    enc_left--;
                    if (enc_left == 0)
                    begin
                        phase = (hdrs_left == 0) ? PH_IDLE : PH_TYPE;
                        upos = 0;
                    end
                    else upos = 0;
                end
            end
            PH_TYPE:
            begin
                if (upos == 1) raw_idx = b;
                if (upos == 3)
                begin
                    if (type_cnt < MAX_TYPES)
                    begin
                        poss_elems[type_cnt] = raw_idx;
                        type_cnt++;
                    end
                    hdrs_left--;
                    upos = 0;
                    if (hdrs_left == 0) phase = PH_IDLE;
                end
                else upos++;
            end
            default: ;
        endcase
    endfunction

    function automatic void status_fail();
        st_fault = 1'b1;
        phase = PH_IDLE;
    endfunction

    function automatic void next_descriptor(int unsigned s);
        upos = 0;
        if (s >= pg_end) phase = PH_IDLE;
        else if (s + HDR_BYTES > pg_end) status_fail();
        else phase = PH_DESC;
    endfunction

    function automatic void next_phy(int unsigned q);
        upos = 0;
        addr_shift = '0;
        phase = (q + PHY_BYTES > sec_end) ? PH_SKIP : PH_PHY;
    endfunction

    // Records the match; with EIIOE clear, converts the index to one that counts an overall element per type.
    function automatic void take_hit();
        int unsigned idx = raw_idx;
        int unsigned add = 0;
        match_seen = 1'b1;
        phase = PH_IDLE;
        if (eiioe)
        begin
            hit_ok = 1'b1;
            hit_idx = idx;
            return;
        end
        if (!cfg_ok) return;
        for (int i = 0; i < type_cnt && i < MAX_TYPES; i++)
        begin
            add++;
            if (idx < poss_elems[i])
            begin
                hit_ok = 1'b1;
                hit_idx = (idx + add) & 9'h1FF;
                return;
            end
            idx -= poss_elems[i];
        end
    endfunction

    function automatic void status_byte(int unsigned p, logic [7:0] b);
        bit qual;
        bit tail = 1'b0;
        if (p < HDR_BYTES)
        begin
            if (p == 0)
            begin
                if (b != AES_CODE) phase = PH_IDLE;
            end
            else if (p == 2) pg_end = b << 8;
            else if (p == 3)
            begin
                pg_end = (pg_end | b) + 4;
                if (pg_end > MAX_PAGE_BYTES) status_fail();
            end
            return;
        end
        if (p >= pg_end) return;
        case (phase)
            PH_HDR:
            begin
                if (p == 7) next_descriptor(8);
                return;
            end
            PH_DESC:
            begin
                if (upos == 0) desc_flags = b;
                else if (upos == 1)
                begin
                    if (b < 2)
                    begin
                        status_fail();
                        return;
                    end
                    sec_end = p + 1 + b;
                end
                else if (upos == 2) eiioe = b[0];
                else
                begin
                    qual = desc_flags[3:0] == PROTO_SAS && desc_flags[4] && !desc_flags[7];
                    raw_idx = b;
                    upos = 0;
                    if (!qual) phase = PH_SKIP;
                    else if (sec_end > pg_end)
                    begin
                        status_fail();
                        return;
                    end
                    else if (sec_end < p + 1 + 4) phase = PH_SKIP;
                    else
                    begin
                        phase = PH_SAS;
                        return;
                    end
                    tail = 1'b1;
                end
                if (!tail)
                begin
                    upos++;
                    return;
                end
            end
            PH_SAS:
            begin
                if (upos == 0) phys_left = b;
                else if (upos == 1) slot_ok = (b[7:6] == 2'b00);
                if (upos == 3)
                begin
                    if (!slot_ok || phys_left == 0) phase = PH_SKIP;
                    else next_phy(p + 1);
                end
                else upos++;
            end
            PH_PHY:
            begin
                if (upos >= 12 && upos < 20) addr_shift = {addr_shift[55:0], b};
                if (upos == PHY_BYTES - 1)
                begin
                    if (addr_shift == target_addr)
                    begin
                        take_hit();
                        return;
                    end
                    phys_left--;
                    if (phys_left == 0) phase = PH_SKIP;
                    else next_phy(p + 1);
                end
                else upos++;
            end
            PH_SKIP: ;
            default: return;
        endcase
        if ((phase == PH_SAS || phase == PH_PHY || phase == PH_SKIP) && p + 1 == sec_end)
            next_descriptor(sec_end);
    endfunction

    function automatic void locate_slot(page_beat_t bt);
        int unsigned p;
        bit trunc, fault;
        slot_result_t r;
        if (in_page && bt.mode != cur_mode)
        begin
            if (!cur_mode)
            begin
                cfg_fault = 1'b1;
                cfg_ok = 1'b0;
            end
            in_page = 1'b0;
        end
        if (!in_page) begin_page(bt.mode);
        p = pos;
        if (!bt.mode) cfg_byte(p, bt.data);
        else status_byte(p, bt.data);
        if (pos < POS_CAP) pos++;
        if (!bt.eop) return;
        in_page = 1'b0;
        trunc = (p < 3) || (p + 1 < pg_end);
        if (!bt.mode)
        begin
            if (trunc) cfg_fault = 1'b1;
            cfg_ok = !cfg_fault && code_ok;
            return;
        end
        if (trunc) st_fault = 1'b1;
        fault = st_fault || cfg_fault;
        r.found = !fault && match_seen && hit_ok;
        r.element_index = r.found ? hit_idx[8:0] : 9'd0;
        r.page_fault = fault;
        slot_results_q.push_back(r);
    endfunction

    initial
    begin
        begin_page(1'b0);
        begin_page(1'b1);
        in_page = 1'b0;
        cur_mode = 1'b0;
        for (int i = 0; i < MAX_TYPES; i++) poss_elems[i] = '0;
    end

    // ------------------------------------------------------------------
    // Stream driver and result monitor.
    // ------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            page_beat_t nxt;
            if (s_axis_tvalid && s_axis_tready)
                locate_slot({s_axis_tuser, s_axis_tdata, s_axis_tlast});
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 11) == 0)
                begin
                    send_gap = $urandom_range(0, 7);
                    s_axis_tvalid <= 1'b0;
                end
                else if (beat_q.size() > 0)
                begin
                    nxt = beat_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= nxt.mode;
                    s_axis_tdata <= nxt.data;
                    s_axis_tlast <= nxt.eop;
                end
                else s_axis_tvalid <= 1'b0;
            end
        end
    end

    int recv_stall = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            slot_result_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (slot_results_q.size() == 0)
                begin
                    $error("result beat with nothing expected: tdata=%h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = slot_results_q.pop_front();
                    if (want.found) hits_seen++;
                    if (want.page_fault) faults_seen++;
                    if (m_axis_tdata[0] !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, m_axis_tdata[0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[9:1] !== want.element_index)
                    begin
                        $error("element_index: expected %0d, actual %0d",
                               want.element_index, m_axis_tdata[9:1]);
                        mismatches++;
                    end
                    if (m_axis_tdata[10] !== want.page_fault)
                    begin
                        $error("page_fault: expected %0d, actual %0d",
                               want.page_fault, m_axis_tdata[10]);
                        mismatches++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end
            else m_axis_tready <= 1'b1;
        end
    end

    // Counts cycles in which no beat and no register write goes through.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Page builders.
    // ------------------------------------------------------------------
    logic [7:0] pg[$];
    int         type_sum;

    function automatic void set_length();
        int unsigned len = pg.size() - 4;
        pg[2] = len[15:8];
        pg[3] = len[7:0];
    endfunction

    function automatic void build_config(int n_enc, int max_types, bit big_counts);
        int nt[$];
        int total = 0;
        int txt = 0;
        int c, tl, l;
        pg = {};
        type_sum = 0;
        pg.push_back(CFG_CODE);
        pg.push_back(8'(n_enc - 1));
        pg.push_back(8'h00);
        pg.push_back(8'h00);
        repeat (4) pg.push_back(8'($urandom));
        for (int e = 0; e < n_enc; e++)
        begin
            nt.push_back($urandom_range(0, max_types));
            total += nt[e];
            l = $urandom_range(0, 12);
            pg.push_back(8'($urandom));
            pg.push_back(8'($urandom));
            pg.push_back(8'(nt[e]));
            pg.push_back(8'(l));
            repeat (l) pg.push_back(8'($urandom));
        end
        for (int t = 0; t < total; t++)
        begin
            c = big_counts ? $urandom_range(0, 255) : $urandom_range(0, 6);
            tl = $urandom_range(0, 3);
            txt += tl;
            if (t < MAX_TYPES) type_sum += c;
            pg.push_back(8'($urandom));
            pg.push_back(8'(c));
            pg.push_back(8'($urandom));
            pg.push_back(8'(tl));
        end
        repeat (txt) pg.push_back(8'($urandom));
        set_length();
    endfunction

    function automatic void build_status(int n_desc, int hit_pct);
        int nph, pad, bl;
        logic [63:0] a;
        pg = {};
        pg.push_back(AES_CODE);
        pg.push_back(8'($urandom));
        pg.push_back(8'h00);
        pg.push_back(8'h00);
        repeat (4) pg.push_back(8'($urandom));
        for (int d = 0; d < n_desc; d++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                nph = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
                bl = 6 + PHY_BYTES * nph + pad;
                pg.push_back({1'b0, 2'($urandom), 1'b1, PROTO_SAS});
                pg.push_back(8'(bl));
                pg.push_back(8'($urandom));
                pg.push_back(($urandom_range(0, 2) != 0) ?
                             8'($urandom_range(0, type_sum + 1)) : 8'($urandom));
                pg.push_back(8'(nph));
                pg.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) :
                             {2'b00, 6'($urandom)});
                pg.push_back(8'($urandom));
                pg.push_back(8'($urandom));
                for (int k = 0; k < nph; k++)
                begin
                    a = {$urandom, $urandom};
                    if ($urandom_range(0, 99) < hit_pct) a = target_addr;
                    else if ($urandom_range(0, 4) == 0) a = target_addr ^ (64'd1 << $urandom_range(0, 63));
                    repeat (12) pg.push_back(8'($urandom));
                    for (int j = 7; j >= 0; j--) pg.push_back(a[8*j +: 8]);
                    repeat (8) pg.push_back(8'($urandom));
                end
                repeat (pad) pg.push_back(8'($urandom));
            end
            else
            begin
                bl = $urandom_range(2, 40);
                pg.push_back(8'($urandom));
                pg.push_back(8'(bl));
                repeat (bl) pg.push_back(8'($urandom));
            end
        end
        set_length();
    endfunction

    // Queues the first cut bytes of the page; without an end mark the page is left open.
    task automatic send_page(bit mode, int cut, bit close);
        for (int i = 0; i < cut; i++)
            beat_q.push_back({mode, pg[i], close && (i == cut - 1)});
        pages_sent++;
    endtask

    task automatic send_whole(bit mode);
        send_page(mode, pg.size(), 1'b1);
    endtask

    task automatic settle();
        while (beat_q.size() != 0 || s_axis_tvalid || slot_results_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_target(logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_TARGET;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        target_addr = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // One damaged or clean random page; status pages are the common case.
    task automatic random_page();
        int r = $urandom_range(0, 99);
        bit mode = ($urandom_range(0, 7) != 0);
        if (mode) build_status($urandom_range(1, 4), 35);
        else build_config($urandom_range(1, 3), 6, $urandom_range(0, 9) == 0);
        if (r < 6)
        begin
            pg[$urandom_range(0, pg.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
            send_whole(mode);
        end
        else if (r < 10) send_page(mode, $urandom_range(1, pg.size() - 1), 1'b1);
        else if (r < 13) send_page(mode, $urandom_range(1, pg.size() - 1), 1'b0);
        else if (r < 16)
        begin
            pg = {};
            repeat ($urandom_range(1, 20)) pg.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 0) pg[0] = mode ? AES_CODE : CFG_CODE;
            send_whole(mode);
        end
        else send_whole(mode);
    endtask

    initial
    begin
        int sent;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, target at zero first.
        write_target(64'd0);
        build_config(2, 4, 1'b0);
        send_whole(1'b0);
        build_status(2, 100);
        send_whole(1'b1);
        build_status(3, 0);
        send_whole(1'b1);
        settle();

        write_target(64'hFFFF_FFFF_FFFF_FFFF);
        build_status(1, 100);
        pg[10] = 8'h00;                  // index correction through the type table
        send_whole(1'b1);
        build_status(1, 100);
        pg[10] = 8'h01;
        send_whole(1'b1);
        build_status(1, 100);
        pg[0] = 8'h0b;                   // wrong page code
        send_whole(1'b1);
        build_status(2, 100);
        pg[9] = 8'h01;                   // descriptor length below two
        send_whole(1'b1);
        build_status(1, 100);
        pg[9] = 8'hFF;                   // first descriptor overruns the page
        send_whole(1'b1);
        pg = {AES_CODE, 8'h00};          // ended before the length
        send_whole(1'b1);
        build_status(1, 0);
        pg[2] = 8'h0F;
        pg[3] = 8'hFD;                   // one byte over the maximum length
        send_whole(1'b1);
        // Exactly the maximum length, made of descriptors that are skipped.
        pg = {AES_CODE, 8'h00, 8'h0F, 8'hFC, 8'h00, 8'h00, 8'h00, 8'h00};
        repeat (15)
        begin
            pg.push_back(8'h00);
            pg.push_back(8'hFF);
            repeat (255) pg.push_back(8'($urandom));
        end
        pg.push_back(8'h05);
        pg.push_back(8'd231);
        repeat (231) pg.push_back(8'($urandom));
        send_whole(1'b1);
        // Over-long stream that drives the position counter into saturation.
        pg = {AES_CODE, 8'h00, 8'hFF, 8'hFF};
        repeat (131100) pg.push_back(8'($urandom));
        send_whole(1'b1);
        settle();

        write_target({$urandom, $urandom});
        build_config(1, 8, 1'b0);
        pg[0] = 8'h02;                   // configuration page with a wrong code
        send_whole(1'b0);
        build_status(1, 100);
        send_whole(1'b1);
        build_config(2, 3, 1'b0);
        send_page(1'b0, 9, 1'b0);        // dropped by a switch to a status page
        build_status(1, 100);
        send_whole(1'b1);
        build_config(2, 40, 1'b1);       // can hold more type headers than are kept
        send_whole(1'b0);
        build_status(3, 60);
        send_whole(1'b1);
        build_config(1, 0, 1'b0);        // no type headers at all
        send_whole(1'b0);
        build_status(2, 100);
        send_whole(1'b1);
        settle();

        // Random part in phases with a new target each time.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_target(ph == 4 ? 64'hFFFF_FFFF_FFFF_FFFF :
                         ph == 1 ? 64'd0 : {$urandom, $urandom});
            calm = (ph == 4);
            build_config($urandom_range(1, 3), 6, 1'b0);
            send_whole(1'b0);
            sent = 0;
            while (sent < 300 || sent < 2000 && pages_sent % 20 != 0)
            begin
                while (beat_q.size() > 400) @(posedge clk);
                sent -= beat_q.size();
                random_page();
                sent += beat_q.size();
            end
            settle();
        end

        $display("%0d pages streamed, %0d status results checked (%0d hits, %0d faults).",
                 pages_sent, results_seen, hits_seen, faults_seen);
        if (mismatches == 0 && slot_results_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
